### hw/rtl/bfpa_pkg.sv
// Package for the best-fit partition allocator.
// Holds field widths, request codes, the result record and default parameters.
// No dependencies.
package bfpa_pkg;

  localparam int unsigned PartitionsDef = 16;
  localparam int unsigned SizeBitsDef   = 16;

  localparam int unsigned KindW   = 2;
  localparam int unsigned SizeW   = 16;
  localparam int unsigned IdxOutW = 4;
  localparam int unsigned ProcW   = 8;
  localparam int unsigned FragW   = 20;
  localparam int unsigned FailW   = 8;

  localparam logic [ProcW-1:0] ProcMax = '1;
  localparam logic [FailW-1:0] FailMax = '1;
  localparam logic [FragW-1:0] FragMax = '1;

  typedef enum logic [KindW-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_ALLOC  = 2'd2,
    REQ_REPORT = 2'd3
  } req_e;

  typedef struct packed {
    logic               granted;
    logic [IdxOutW-1:0] partition_index;
    logic [ProcW-1:0]   process_number;
    logic [SizeW-1:0]   leftover;
    logic               table_full;
    logic [FragW-1:0]   internal_frag;
    logic [FragW-1:0]   external_frag;
    logic               external_present;
    logic [FailW-1:0]   failed_count;
  } rsp_t;

endpackage

### hw/rtl/bfpa_req_if.sv
// Request channel of the best-fit partition allocator.
// Valid/ready handshake with the request kind and size; uses bfpa_pkg.
interface bfpa_req_if
  import bfpa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] req_type;
  logic [SizeW-1:0] size_value;

  modport source (output valid, output req_type, output size_value, input ready);
  modport sink   (input valid, input req_type, input size_value, output ready);
endinterface

### hw/rtl/bfpa_rsp_if.sv
// Result channel of the best-fit partition allocator.
// Valid/ready handshake with one result record per request; uses bfpa_pkg.
interface bfpa_rsp_if
  import bfpa_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               granted;
  logic [IdxOutW-1:0] partition_index;
  logic [ProcW-1:0]   process_number;
  logic [SizeW-1:0]   leftover;
  logic               table_full;
  logic [FragW-1:0]   internal_frag;
  logic [FragW-1:0]   external_frag;
  logic               external_present;
  logic [FailW-1:0]   failed_count;

  modport source (
    output valid, output granted, output partition_index, output process_number,
    output leftover, output table_full, output internal_frag, output external_frag,
    output external_present, output failed_count, input ready
  );
  modport sink (
    input valid, input granted, input partition_index, input process_number,
    input leftover, input table_full, input internal_frag, input external_frag,
    input external_present, input failed_count, output ready
  );
endinterface

### hw/rtl/best_fit_partition_allocator.sv
// Best-fit fixed-partition allocator: top level with sequencer and size memory.
// Depends on bfpa_pkg, bfpa_req_if and bfpa_rsp_if.
//
//   channel  dir  modport  payload
//   req_i    in   sink     req_type, size_value
//   rsp_o    out  source   granted .. failed_count (one result per request)
//
// Clear and load go straight from idle to the done state; allocate and report pass
// through scan and finish states, scanning the filled partitions with one size-memory
// read per cycle feeding a single compare/add unit. No clearing pass: the size
// memory is only read below the fill count. Reset is asynchronous, active low. The
// result register lets the next request enter while a result waits on rsp_o.ready.
module best_fit_partition_allocator
  import bfpa_pkg::*;
#(
  parameter int unsigned PARTITIONS = PartitionsDef,
  parameter int unsigned SIZE_BITS  = SizeBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bfpa_req_if.sink   req_i,
  bfpa_rsp_if.source rsp_o
);

  localparam int unsigned SW   = (SIZE_BITS < SizeW) ? SIZE_BITS : SizeW;
  localparam int unsigned IDXW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int unsigned CNTW = $clog2(PARTITIONS + 1);
  localparam int unsigned SUMW = SW + CNTW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN,
    ST_DONE
  } state_e;

  function automatic logic [IdxOutW-1:0] idx_out(input logic [IDXW-1:0] i);
    logic [IDXW+IdxOutW-1:0] w;
    w = {{IdxOutW{1'b0}}, i};
    return w[IdxOutW-1:0];
  endfunction

  function automatic logic [SizeW-1:0] size_out(input logic [SW-1:0] s);
    logic [SW+SizeW-1:0] w;
    w = {{SizeW{1'b0}}, s};
    return w[SizeW-1:0];
  endfunction

  function automatic logic [FragW-1:0] sat_frag(input logic [SUMW-1:0] v);
    logic [SUMW+FragW-1:0] w;
    w = {{FragW{1'b0}}, v};
    return (w > (SUMW + FragW)'(FragMax)) ? FragMax : w[FragW-1:0];
  endfunction

  state_e               state_q;
  req_e                 kind_q;
  logic [SW-1:0]        sz_q;
  logic [CNTW-1:0]      count_q;
  logic [ProcW-1:0]     next_proc_q;
  logic [FailW-1:0]     fail_q;
  logic [SW-1:0]        small_fail_q;
  logic [PARTITIONS-1:0] owned_q;
  logic [CNTW-1:0]      idx_q;
  logic                 cmp_vld_q;
  logic [IDXW-1:0]      cmp_idx_q;
  logic                 found_q;
  logic [IDXW-1:0]      best_idx_q;
  logic [SW-1:0]        best_size_q;
  logic [SUMW-1:0]      int_sum_q;
  logic [SUMW-1:0]      ext_sum_q;
  rsp_t                 res_q;
  rsp_t                 out_q;
  logic                 out_vld_q;

  logic [SW-1:0]        mem_q [PARTITIONS];
  logic [SW-1:0]        rdata_q;

  logic                 req_acc;
  logic [SW-1:0]        req_sz;
  logic                 full;
  logic                 rd_en;
  logic                 mem_we;
  logic [IDXW-1:0]      mem_waddr;
  logic [SW-1:0]        mem_wdata;
  logic [SW-1:0]        remain;
  logic                 fit;
  logic                 cur_owned;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign req_sz      = req_i.size_value[SW-1:0];
  assign full        = (count_q >= CNTW'(PARTITIONS));
  assign rd_en       = (state_q == ST_SCAN) && (idx_q < count_q);
  assign remain      = best_size_q - sz_q;
  assign cur_owned   = owned_q[cmp_idx_q];
  assign fit         = !cur_owned && (rdata_q >= sz_q) && (!found_q || rdata_q < best_size_q);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IDXW-1:0];
    mem_wdata = req_sz;
    if (req_acc && req_e'(req_i.req_type) == REQ_LOAD && !full) begin
      mem_we = 1'b1;
    end else if (state_q == ST_FIN && kind_q == REQ_ALLOC && found_q) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_q;
      mem_wdata = remain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[idx_q[IDXW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= REQ_CLEAR;
      sz_q         <= '0;
      count_q      <= '0;
      next_proc_q  <= ProcW'(1);
      fail_q       <= '0;
      small_fail_q <= '1;
      owned_q      <= '0;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_idx_q    <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_size_q  <= '0;
      int_sum_q    <= '0;
      ext_sum_q    <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (state_q == ST_DONE && (!out_vld_q || rsp_o.ready)) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            kind_q    <= req_e'(req_i.req_type);
            sz_q      <= req_sz;
            idx_q     <= '0;
            cmp_vld_q <= 1'b0;
            found_q   <= 1'b0;
            int_sum_q <= '0;
            ext_sum_q <= '0;
            unique case (req_e'(req_i.req_type))
              REQ_CLEAR: begin
                count_q      <= '0;
                next_proc_q  <= ProcW'(1);
                fail_q       <= '0;
                small_fail_q <= '1;
                owned_q      <= '0;
                state_q      <= ST_DONE;
              end
              REQ_LOAD: begin
                if (full) begin
                  res_q.table_full <= 1'b1;
                end else begin
                  owned_q[count_q[IDXW-1:0]] <= 1'b0;
                  res_q.partition_index      <= idx_out(count_q[IDXW-1:0]);
                  count_q                    <= count_q + CNTW'(1);
                end
                state_q <= ST_DONE;
              end
              REQ_ALLOC: begin
                res_q.process_number <= next_proc_q;
                if (next_proc_q != ProcMax) begin
                  next_proc_q <= next_proc_q + ProcW'(1);
                end
                state_q <= ST_SCAN;
              end
              REQ_REPORT: begin
                state_q <= ST_SCAN;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            idx_q     <= idx_q + CNTW'(1);
            cmp_idx_q <= idx_q[IDXW-1:0];
            cmp_vld_q <= 1'b1;
          end else begin
            cmp_vld_q <= 1'b0;
            if (!cmp_vld_q) begin
              state_q <= ST_FIN;
            end
          end
          if (cmp_vld_q) begin
            if (kind_q == REQ_ALLOC) begin
              if (fit) begin
                found_q     <= 1'b1;
                best_idx_q  <= cmp_idx_q;
                best_size_q <= rdata_q;
              end
            end else if (cur_owned) begin
              int_sum_q <= int_sum_q + SUMW'(rdata_q);
            end else begin
              ext_sum_q <= ext_sum_q + SUMW'(rdata_q);
            end
          end
        end
        ST_FIN: begin
          if (kind_q == REQ_ALLOC) begin
            if (found_q) begin
              owned_q[best_idx_q]   <= 1'b1;
              res_q.granted         <= 1'b1;
              res_q.partition_index <= idx_out(best_idx_q);
              res_q.leftover        <= size_out(remain);
            end else begin
              if (fail_q != FailMax) begin
                fail_q <= fail_q + FailW'(1);
              end
              if (sz_q < small_fail_q) begin
                small_fail_q <= sz_q;
              end
            end
          end else begin
            res_q.internal_frag    <= sat_frag(int_sum_q);
            res_q.external_frag    <= sat_frag(ext_sum_q);
            res_q.external_present <= (fail_q != '0) && (ext_sum_q >= SUMW'(small_fail_q));
            res_q.failed_count     <= fail_q;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_q   <= res_q;
            res_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.granted          = out_q.granted;
  assign rsp_o.partition_index  = out_q.partition_index;
  assign rsp_o.process_number   = out_q.process_number;
  assign rsp_o.leftover         = out_q.leftover;
  assign rsp_o.table_full       = out_q.table_full;
  assign rsp_o.internal_frag    = out_q.internal_frag;
  assign rsp_o.external_frag    = out_q.external_frag;
  assign rsp_o.external_present = out_q.external_present;
  assign rsp_o.failed_count     = out_q.failed_count;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(PARTITIONS))
    else $error("fill count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !req_i.ready)
    else $error("request taken while sequencer busy");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> idx_q <= count_q)
    else $error("scan index past fill count");

  a_proc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_proc_q != '0)
    else $error("process number wrapped to zero");

  a_grant_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.granted |-> !rsp_o.table_full && rsp_o.failed_count == '0)
    else $error("grant result carries fields of another request kind");
`endif

endmodule

### sim/tb_best_fit_partition_allocator.sv
// Testbench for best_fit_partition_allocator: directed and random request streams with
// random idling on both channels, checked in order against a best-fit allocation ledger.
// Depends on bfpa_pkg, bfpa_req_if, bfpa_rsp_if and the allocator RTL.
module tb_best_fit_partition_allocator
  import bfpa_pkg::*;
();

  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned SqueezeAfter = 120;
  localparam int unsigned SqueezeLen   = 400;
  localparam int unsigned DrainCycles  = 30;

  class partition_ledger;
    logic [SizeW-1:0] sizes [PartitionsDef];
    bit               owned [PartitionsDef];
    int unsigned      filled;
    int unsigned      next_proc;
    int unsigned      fail_cnt;
    logic [SizeW-1:0] min_failed;
    rsp_t             pending_results [$];
    int unsigned      mismatches;

    function new();
      restore_reset();
      mismatches = 0;
    endfunction

    function void restore_reset();
      foreach (sizes[i]) begin
        sizes[i] = '0;
        owned[i] = 1'b0;
      end
      filled     = 0;
      next_proc  = 1;
      fail_cnt   = 0;
      min_failed = '1;
    endfunction

    function void record_request(req_e kind, logic [SizeW-1:0] sz);
      rsp_t             r;
      bit               found;
      int unsigned      best;
      logic [SizeW-1:0] best_size;
      int unsigned      inner_sum;
      int unsigned      outer_sum;
      int unsigned      i;
      r         = '0;
      found     = 1'b0;
      best      = 0;
      best_size = '0;
      inner_sum = 0;
      outer_sum = 0;
      case (kind)
        REQ_CLEAR: restore_reset();
        REQ_LOAD: begin
          if (filled >= PartitionsDef) begin
            r.table_full = 1'b1;
          end else begin
            sizes[filled]     = sz;
            owned[filled]     = 1'b0;
            r.partition_index = IdxOutW'(filled);
            filled++;
          end
        end
        REQ_ALLOC: begin
          r.process_number = ProcW'(next_proc);
          if (next_proc < ProcMax) next_proc++;
          for (i = 0; i < filled; i++) begin
            if (!owned[i] && sizes[i] >= sz && (!found || sizes[i] < best_size)) begin
              found     = 1'b1;
              best      = i;
              best_size = sizes[i];
            end
          end
          if (found) begin
            owned[best]       = 1'b1;
            sizes[best]       = best_size - sz;
            r.granted         = 1'b1;
            r.partition_index = IdxOutW'(best);
            r.leftover        = sizes[best];
          end else begin
            if (fail_cnt < FailMax) fail_cnt++;
            if (sz < min_failed) min_failed = sz;
          end
        end
        default: begin
          for (i = 0; i < filled; i++) begin
            if (owned[i]) inner_sum += sizes[i];
            else outer_sum += sizes[i];
          end
          r.internal_frag    = (inner_sum > FragMax) ? FragMax : FragW'(inner_sum);
          r.external_frag    = (outer_sum > FragMax) ? FragMax : FragW'(outer_sum);
          r.external_present = (fail_cnt != 0) && (outer_sum >= min_failed);
          r.failed_count     = FailW'(fail_cnt);
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      check_field("granted", want.granted, got.granted);
      check_field("partition_index", want.partition_index, got.partition_index);
      check_field("process_number", want.process_number, got.process_number);
      check_field("leftover", want.leftover, got.leftover);
      check_field("table_full", want.table_full, got.table_full);
      check_field("internal_frag", want.internal_frag, got.internal_frag);
      check_field("external_frag", want.external_frag, got.external_frag);
      check_field("external_present", want.external_present, got.external_present);
      check_field("failed_count", want.failed_count, got.failed_count);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  bfpa_req_if req_if ();
  bfpa_rsp_if rsp_if ();

  best_fit_partition_allocator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  partition_ledger book = new();
  int unsigned     send_calm;
  int unsigned     results_seen;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SizeW-1:0] pick_size();
    int unsigned mode;
    mode = $urandom_range(0, 11);
    if (mode < 4) return SizeW'($urandom_range(0, 300));
    if (mode < 7) return SizeW'($urandom);
    if (mode == 7) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (mode < 10 && book.filled != 0)
      return book.sizes[$urandom_range(0, book.filled - 1)] - SizeW'($urandom_range(0, 3));
    return SizeW'($urandom_range(0, 4095));
  endfunction

  task automatic send_req(req_e kind, logic [SizeW-1:0] sz);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.size_value <= sz;
    do @(posedge clk_i); while (!req_if.ready);
    book.record_request(kind, sz);
  endtask

  task automatic run_directed();
    logic [SizeW-1:0] seed_sizes [16];
    seed_sizes = '{16'd100, 16'd0, 16'hFFFF, 16'd300, 16'd100, 16'd50, 16'd1000, 16'd7,
                   16'h8000, 16'd200, 16'd100, 16'd4096, 16'd1, 16'd255, 16'h5555, 16'hAAAA};
    send_req(REQ_REPORT, 16'hFFFF);
    send_req(REQ_ALLOC, 16'hFFFF);
    foreach (seed_sizes[i]) send_req(REQ_LOAD, seed_sizes[i]);
    send_req(REQ_LOAD, 16'h1234);
    send_req(REQ_ALLOC, 16'd0);
    send_req(REQ_ALLOC, 16'd100);
    send_req(REQ_ALLOC, 16'hFFFF);
    send_req(REQ_ALLOC, 16'hFFFF);
    send_req(REQ_REPORT, 16'd0);
    send_req(REQ_CLEAR, 16'hFFFF);
  endtask

  task automatic run_session(int unsigned n_items, int unsigned alloc_pct);
    int unsigned loads;
    int unsigned roll;
    send_req(REQ_CLEAR, SizeW'($urandom));
    loads = $urandom_range(1, PartitionsDef + 2);
    repeat (loads) send_req(REQ_LOAD, pick_size());
    repeat (n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) send_req(REQ_ALLOC, pick_size());
      else if (roll < 97) send_req(REQ_REPORT, SizeW'($urandom));
      else if (roll < 99) send_req(REQ_LOAD, pick_size());
      else send_req(REQ_CLEAR, SizeW'($urandom));
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm;
    bit          squeezed;
    rsp_t        got;
    stall_left   = 0;
    calm         = 0;
    squeezed     = 1'b0;
    results_seen = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.granted, rsp_if.partition_index, rsp_if.process_number,
                rsp_if.leftover, rsp_if.table_full, rsp_if.internal_frag,
                rsp_if.external_frag, rsp_if.external_present, rsp_if.failed_count};
        book.match_result(got);
        results_seen++;
      end
      if (!squeezed && results_seen == SqueezeAfter) begin
        squeezed   = 1'b1;
        stall_left = SqueezeLen;
      end else if (stall_left == 0) begin
        stall_left = pick_gap(calm);
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL best_fit_partition_allocator");
    $finish;
  end

  initial begin : stimulus
    send_calm         = 0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_CLEAR;
    req_if.size_value <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    repeat (6) run_session(35, 70);
    run_session(250, 90);
    req_if.valid <= 1'b0;

    while (book.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending_results.size() == 0) begin
      $display("PASS best_fit_partition_allocator");
    end else begin
      $display("FAIL best_fit_partition_allocator");
    end
    $finish;
  end

endmodule

### best_fit_partition_allocator.f
hw/rtl/bfpa_pkg.sv
hw/rtl/bfpa_req_if.sv
hw/rtl/bfpa_rsp_if.sv
hw/rtl/best_fit_partition_allocator.sv
sim/tb_best_fit_partition_allocator.sv
